// File: src/tsbc_pkg.sv
package tsbc_pkg;

    // Element type codes and their byte widths
    localparam logic [7:0] ELEM_W4_A = 8'd0;
    localparam logic [7:0] ELEM_W4_B = 8'd26;
    localparam logic [7:0] ELEM_W2   = 8'd1;
    localparam logic [7:0] ELEM_W8   = 8'd27;

    localparam int unsigned DATA_W = 64;

    typedef enum logic [2:0] {
        ERR_NONE           = 3'd0,
        ERR_OFFSET_NO_VIEW = 3'd1,
        ERR_BAD_TYPE       = 3'd2,
        ERR_COUNT          = 3'd3,
        ERR_SPAN_OVF       = 3'd4,
        ERR_FLOOR_ALIGN    = 3'd5,
        ERR_SUPPLIED       = 3'd6,
        ERR_NO_BACKING     = 3'd7
    } err_code_t;

    // Load strobes for the two register stages of a split multiplier
    typedef struct packed {
        logic load_pp;
        logic load_res;
    } mul_ctl_t;

    // Per-item context that travels down pipeline stages 1 to 7
    typedef struct packed {
        logic [DATA_W-1:0] off;
        logic [DATA_W-1:0] supplied;
        logic [3:0]        width;
        logic              off_err;
        logic              type_err;
        logic              neg_err;
        logic              zero;
    } ctx_t;

    function automatic logic [3:0] width_of(input logic [7:0] code);
        logic [3:0] w;
        case (code) inside
            ELEM_W4_A, ELEM_W4_B: w = 4'd4;
            ELEM_W2:              w = 4'd2;
            ELEM_W8:              w = 4'd8;
            default:              w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

// File: src/tsbc_mul64.sv
// Overflow-checked 64 x 64 unsigned multiply over two register stages:
// 32 x 32 partial products first, then one combining add.
module tsbc_mul64
(
    input  logic               clk,
    input  tsbc_pkg::mul_ctl_t ctl,
    input  logic [63:0]        a,
    input  logic [63:0]        b,
    output logic [63:0]        product,
    output logic               ovf
);

    logic [63:0] ll_reg, hl_reg, lh_reg;
    logic        hh_reg;
    logic [63:0] ll_next, hl_next, lh_next;
    logic        hh_next;
    logic [63:0] prod_reg, prod_next;
    logic        ovf_reg, ovf_next;
    logic [63:0] cross_pp;
    logic [64:0] sum;

    always_comb
    begin
        ll_next = 64'(a[31:0]) * 64'(b[31:0]);
        hl_next = 64'(a[63:32]) * 64'(b[31:0]);
        lh_next = 64'(a[31:0]) * 64'(b[63:32]);
        hh_next = (a[63:32] != 32'd0) && (b[63:32] != 32'd0);
    end

    // At most one cross term is nonzero unless both high halves are set,
    // and that case overflows anyway, so an OR merges them.
    always_comb
    begin
        cross_pp  = hl_reg | lh_reg;
        sum       = {1'b0, ll_reg} + {1'b0, cross_pp[31:0], 32'd0};
        prod_next = sum[63:0];
        ovf_next  = hh_reg || (cross_pp[63:32] != 32'd0) || sum[64];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_pp)
        begin
            ll_reg <= ll_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            hh_reg <= hh_next;
        end
        if (ctl.load_res)
        begin
            prod_reg <= prod_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign product = prod_reg;
    assign ovf     = ovf_reg;

endmodule

// File: src/tensor_span_backing_checker_top.sv
// Tensor span and backing checker. Each item is one four-dimension strided
// descriptor; the block returns exactly one result per item: ok with the byte
// span [view_offset, span_high), the empty flag and the effective backing
// size, or ok low with an error code and all other result fields zero. Checks
// take the error codes in order and the first failure wins. The block takes
// one item per cycle while in_stall is low, and each item passes through
// stages 1 to 8; the depth is set by the chain of three overflow-checked 64-bit
// multiplications that forms the element count, each split into 32 x 32
// partial products over two stages. Every stage advances on its own when the
// next one has room, so bubbles close up and in_stall rises only when the
// result register is held and all eight stages carry an item.
module tensor_span_backing_checker_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  element_type,
    input  logic signed [63:0] extent_0,
    input  logic signed [63:0] extent_1,
    input  logic signed [63:0] extent_2,
    input  logic signed [63:0] extent_3,
    input  logic [63:0] stride_0,
    input  logic [63:0] stride_1,
    input  logic [63:0] stride_2,
    input  logic [63:0] stride_3,
    input  logic        view_flag,
    input  logic [63:0] view_offset,
    input  logic [63:0] given_bytes,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [2:0]  error_code,
    output logic [63:0] span_low,
    output logic [63:0] span_high,
    output logic        is_empty,
    output logic [63:0] backing_size
);

    // ------------------------------------------------------------------
    // Stage valids and per-stage load enables. A stage loads when it is
    // empty or its successor loads; stage 8 is the result register.
    // ------------------------------------------------------------------
    logic [8:1] v_reg;
    logic [9:1] en;

    always_comb
    begin
        en[9] = !out_stall;
        for (int k = 8; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_stall = !en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int k = 2; k <= 8; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Context carried by every stage from 1 to 7
    // ------------------------------------------------------------------
    tsbc_pkg::ctx_t ctx_reg [1:7];
    tsbc_pkg::ctx_t ctx_next;

    // Stage 1: input decode
    logic [63:0] ext_in [4];
    logic [63:0] str_in [4];
    logic [63:0] e_reg [4];
    logic [63:0] em1_reg [4];
    logic [63:0] s_reg [4];
    logic [63:0] m01_reg, m23_reg;

    always_comb
    begin
        ext_in[0] = extent_0;
        ext_in[1] = extent_1;
        ext_in[2] = extent_2;
        ext_in[3] = extent_3;
        str_in[0] = stride_0;
        str_in[1] = stride_1;
        str_in[2] = stride_2;
        str_in[3] = stride_3;

        ctx_next.off      = view_offset;
        ctx_next.supplied = given_bytes;
        ctx_next.width    = tsbc_pkg::width_of(element_type);
        ctx_next.off_err  = !view_flag && (view_offset != 64'd0);
        ctx_next.type_err = (tsbc_pkg::width_of(element_type) == 4'd0);
        // Any negative extent is a count error; any zero extent empties it
        ctx_next.neg_err  = ext_in[0][63] | ext_in[1][63] | ext_in[2][63] | ext_in[3][63];
        ctx_next.zero     = (ext_in[0] == 64'd0) || (ext_in[1] == 64'd0) ||
                            (ext_in[2] == 64'd0) || (ext_in[3] == 64'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ctx_reg[1] <= ctx_next;
            for (int d = 0; d < 4; d++)
            begin
                e_reg[d]   <= ext_in[d];
                em1_reg[d] <= ext_in[d] - 64'd1;
                s_reg[d]   <= str_in[d];
            end
            m01_reg <= (stride_0 > stride_1) ? stride_0 : stride_1;
            m23_reg <= (stride_2 > stride_3) ? stride_2 : stride_3;
        end
        for (int k = 2; k <= 7; k++)
        begin
            if (en[k])
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Multipliers: span terms (stages 2-3), count chain (2-3, 4-5, 6-7)
    // ------------------------------------------------------------------
    tsbc_pkg::mul_ctl_t ctl_23, ctl_45, ctl_67;
    assign ctl_23 = '{load_pp: en[2], load_res: en[3]};
    assign ctl_45 = '{load_pp: en[4], load_res: en[5]};
    assign ctl_67 = '{load_pp: en[6], load_res: en[7]};

    logic [63:0] t_prod [4];
    logic        t_ovf [4];

    for (genvar d = 0; d < 4; d++)
    begin : g_term
        tsbc_mul64 u_term
        (
            .clk     (clk),
            .ctl     (ctl_23),
            .a       (em1_reg[d]),
            .b       (s_reg[d]),
            .product (t_prod[d]),
            .ovf     (t_ovf[d])
        );
    end

    logic [63:0] c1_prod, c2_prod, c3_prod;
    logic        c1_ovf, c2_ovf, c3_ovf;
    logic [63:0] e2_s2_reg, e2_s3_reg;
    logic [63:0] e3_s2_reg, e3_s3_reg, e3_s4_reg, e3_s5_reg;

    tsbc_mul64 u_cnt1
    (
        .clk     (clk),
        .ctl     (ctl_23),
        .a       (e_reg[0]),
        .b       (e_reg[1]),
        .product (c1_prod),
        .ovf     (c1_ovf)
    );

    tsbc_mul64 u_cnt2
    (
        .clk     (clk),
        .ctl     (ctl_45),
        .a       (c1_prod),
        .b       (e2_s3_reg),
        .product (c2_prod),
        .ovf     (c2_ovf)
    );

    tsbc_mul64 u_cnt3
    (
        .clk     (clk),
        .ctl     (ctl_67),
        .a       (c2_prod),
        .b       (e3_s5_reg),
        .product (c3_prod),
        .ovf     (c3_ovf)
    );

    // ------------------------------------------------------------------
    // Span sum, floor and supplied compare (stages 2-7)
    // ------------------------------------------------------------------
    logic [63:0] smax2_reg, smax3_reg, smax4_reg, smax5_reg;
    logic [65:0] sa_reg, sb_reg;
    logic        tov4_reg;
    logic        cov4_reg, cov5_reg, cov6_reg, cov7_reg;
    logic [66:0] sum67;
    logic [63:0] high5_reg, high6_reg, high7_reg;
    logic        sov5_reg, sov6_reg, sov7_reg;
    logic [63:0] floor6_reg, floor7_reg;
    logic        lt7_reg;

    assign sum67 = 67'(sa_reg) + 67'(sb_reg);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            e2_s2_reg <= e_reg[2];
            e3_s2_reg <= e_reg[3];
            smax2_reg <= (m01_reg > m23_reg) ? m01_reg : m23_reg;
        end
        if (en[3])
        begin
            e2_s3_reg <= e2_s2_reg;
            e3_s3_reg <= e3_s2_reg;
            smax3_reg <= smax2_reg;
        end
        if (en[4])
        begin
            e3_s4_reg <= e3_s3_reg;
            smax4_reg <= smax3_reg;
            cov4_reg  <= c1_ovf;
            sa_reg    <= 66'(ctx_reg[3].off) + 66'(t_prod[0]) + 66'(t_prod[1]);
            sb_reg    <= 66'(t_prod[2]) + 66'(t_prod[3]) + 66'(ctx_reg[3].width);
            tov4_reg  <= t_ovf[0] | t_ovf[1] | t_ovf[2] | t_ovf[3];
        end
        if (en[5])
        begin
            e3_s5_reg <= e3_s4_reg;
            smax5_reg <= smax4_reg;
            cov5_reg  <= cov4_reg;
            // An empty tensor spans nothing: its end is the view offset
            high5_reg <= ctx_reg[4].zero ? ctx_reg[4].off : sum67[63:0];
            sov5_reg  <= !ctx_reg[4].zero && (tov4_reg || (sum67[66:64] != 3'd0));
        end
        if (en[6])
        begin
            cov6_reg   <= cov5_reg | c2_ovf;
            high6_reg  <= high5_reg;
            sov6_reg   <= sov5_reg;
            floor6_reg <= (high5_reg > smax5_reg) ? high5_reg : smax5_reg;
        end
        if (en[7])
        begin
            cov7_reg   <= cov6_reg;
            high7_reg  <= high6_reg;
            sov7_reg   <= sov6_reg;
            floor7_reg <= floor6_reg;
            lt7_reg    <= ctx_reg[6].supplied < floor6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: pick the first failing check and form the result
    // ------------------------------------------------------------------
    tsbc_pkg::err_code_t code_next, code_reg;
    logic        ok_reg, empty_reg;
    logic [63:0] low_reg, high_reg, eff_reg;
    logic        sup_zero;

    assign sup_zero = (ctx_reg[7].supplied == 64'd0);

    always_comb
    begin
        if (ctx_reg[7].off_err)
        begin
            code_next = tsbc_pkg::ERR_OFFSET_NO_VIEW;
        end
        else if (ctx_reg[7].type_err)
        begin
            code_next = tsbc_pkg::ERR_BAD_TYPE;
        end
        else if (ctx_reg[7].neg_err || cov7_reg || c3_ovf)
        begin
            code_next = tsbc_pkg::ERR_COUNT;
        end
        else if (sov7_reg)
        begin
            code_next = tsbc_pkg::ERR_SPAN_OVF;
        end
        else if (floor7_reg[2:0] != 3'd0)
        begin
            code_next = tsbc_pkg::ERR_FLOOR_ALIGN;
        end
        else if (!sup_zero && (lt7_reg || (ctx_reg[7].supplied[2:0] != 3'd0)))
        begin
            code_next = tsbc_pkg::ERR_SUPPLIED;
        end
        else if (sup_zero && !ctx_reg[7].zero)
        begin
            code_next = tsbc_pkg::ERR_NO_BACKING;
        end
        else
        begin
            code_next = tsbc_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            code_reg <= code_next;
            if (code_next == tsbc_pkg::ERR_NONE)
            begin
                ok_reg    <= 1'b1;
                low_reg   <= ctx_reg[7].off;
                high_reg  <= high7_reg;
                empty_reg <= ctx_reg[7].zero;
                eff_reg   <= sup_zero ? floor7_reg : ctx_reg[7].supplied;
            end
            else
            begin
                // Drop every result field of a rejected descriptor
                ok_reg    <= 1'b0;
                low_reg   <= 64'd0;
                high_reg  <= 64'd0;
                empty_reg <= 1'b0;
                eff_reg   <= 64'd0;
            end
        end
    end

    assign out_valid    = v_reg[8];
    assign ok           = ok_reg;
    assign error_code   = code_reg;
    assign span_low     = low_reg;
    assign span_high    = high_reg;
    assign is_empty     = empty_reg;
    assign backing_size = eff_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result side can move");

    a_reject_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (span_low == 64'd0 && span_high == 64'd0 &&
                                !is_empty && backing_size == 64'd0 &&
                                error_code != tsbc_pkg::ERR_NONE))
        else $error("rejected item carries result fields");

    a_empty_span: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ok && is_empty) |-> (span_high == span_low))
        else $error("empty tensor with a nonzero span");

    a_eff_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ok) |-> (backing_size[2:0] == 3'd0 &&
                               error_code == tsbc_pkg::ERR_NONE))
        else $error("accepted item with unaligned backing size");

endmodule

// File: sim/tensor_span_backing_checker_top_tb.sv
module tensor_span_backing_checker_top_tb;

    // Cycles with no handshake on either side before the run is declared hung
    localparam int unsigned QUIET_LIMIT = 4000;
    // Length of the receiver hold-off used to fill the pipeline
    localparam int unsigned HOLD_CYCLES = 80;
    // Cycles to wait after the last expected result
    localparam int unsigned DRAIN_CYCLES = 16;

    // One descriptor as the sender puts it on the ports
    typedef struct packed {
        logic [7:0]  element_type;
        logic [63:0] extent_0;
        logic [63:0] extent_1;
        logic [63:0] extent_2;
        logic [63:0] extent_3;
        logic [63:0] stride_0;
        logic [63:0] stride_1;
        logic [63:0] stride_2;
        logic [63:0] stride_3;
        logic        view_flag;
        logic [63:0] view_offset;
        logic [63:0] given_bytes;
    } tensor_desc_t;

    // One verdict as the block should return it
    typedef struct packed {
        logic                ok;
        tsbc_pkg::err_code_t code;
        logic [63:0]         span_low;
        logic [63:0]         span_high;
        logic                is_empty;
        logic [63:0]         backing_size;
    } span_verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  element_type = '0;
    logic signed [63:0] extent_0 = '0;
    logic signed [63:0] extent_1 = '0;
    logic signed [63:0] extent_2 = '0;
    logic signed [63:0] extent_3 = '0;
    logic [63:0] stride_0 = '0;
    logic [63:0] stride_1 = '0;
    logic [63:0] stride_2 = '0;
    logic [63:0] stride_3 = '0;
    logic        view_flag = 1'b0;
    logic [63:0] view_offset = '0;
    logic [63:0] given_bytes = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        ok;
    logic [2:0]  error_code;
    logic [63:0] span_low;
    logic [63:0] span_high;
    logic        is_empty;
    logic [63:0] backing_size;

    // Verdicts owed by the block, oldest first
    span_verdict_t verdicts_owed[$];
    int unsigned   mismatch_count = 0;

    // Idle rates in percent; the sender's is used by its own process only
    int unsigned in_idle_pct = 6;
    int unsigned out_idle_pct = 6;

    // A test asks for a hold-off by bumping hold_asked; the receiver serves it
    int unsigned hold_asked = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    int unsigned quiet_cycles = 0;

    tensor_span_backing_checker_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .element_type   (element_type),
        .extent_0       (extent_0),
        .extent_1       (extent_1),
        .extent_2       (extent_2),
        .extent_3       (extent_3),
        .stride_0       (stride_0),
        .stride_1       (stride_1),
        .stride_2       (stride_2),
        .stride_3       (stride_3),
        .view_flag      (view_flag),
        .view_offset    (view_offset),
        .given_bytes    (given_bytes),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .error_code     (error_code),
        .span_low       (span_low),
        .span_high      (span_high),
        .is_empty       (is_empty),
        .backing_size   (backing_size)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Byte width of an element type; zero marks an invalid code
    function automatic logic [63:0] elem_bytes(input logic [7:0] code);
        logic [63:0] w;
        case (code)
            tsbc_pkg::ELEM_W4_A, tsbc_pkg::ELEM_W4_B: w = 64'd4;
            tsbc_pkg::ELEM_W2:                        w = 64'd2;
            tsbc_pkg::ELEM_W8:                        w = 64'd8;
            default:                                  w = 64'd0;
        endcase
        return w;
    endfunction

    // Work out the verdict for one descriptor. Products are formed at 128 bits
    // and sums at 65 bits so that any carry out of 64 bits shows as overflow.
    function automatic span_verdict_t predict_span(input tensor_desc_t d);
        span_verdict_t       v;
        logic [63:0]         ext [4];
        logic [63:0]         str [4];
        logic [63:0]         w;
        logic [63:0]         elems;
        logic [63:0]         hi;
        logic [63:0]         floor_b;
        logic [127:0]        prod;
        logic [64:0]         acc;
        logic                empty;
        tsbc_pkg::err_code_t code;
        ext[0] = d.extent_0;
        ext[1] = d.extent_1;
        ext[2] = d.extent_2;
        ext[3] = d.extent_3;
        str[0] = d.stride_0;
        str[1] = d.stride_1;
        str[2] = d.stride_2;
        str[3] = d.stride_3;
        w = elem_bytes(d.element_type);
        code = tsbc_pkg::ERR_NONE;
        elems = 64'd1;
        hi = d.view_offset;
        floor_b = '0;
        empty = 1'b0;
        v = '0;

        if (!d.view_flag && d.view_offset != 64'd0)
            code = tsbc_pkg::ERR_OFFSET_NO_VIEW;
        else if (w == 64'd0)
            code = tsbc_pkg::ERR_BAD_TYPE;
        else
        begin
            // Sign is checked on every extent, even once the count is zero
            for (int k = 0; k < 4; k++)
            begin
                if (code == tsbc_pkg::ERR_NONE)
                begin
                    prod = {64'd0, elems} * {64'd0, ext[k]};
                    if (ext[k][63] || prod[127:64] != 64'd0)
                        code = tsbc_pkg::ERR_COUNT;
                    else
                        elems = prod[63:0];
                end
            end
        end

        if (code == tsbc_pkg::ERR_NONE)
        begin
            empty = (elems == 64'd0);
            if (!empty)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (code == tsbc_pkg::ERR_NONE)
                    begin
                        prod = {64'd0, ext[k] - 64'd1} * {64'd0, str[k]};
                        acc = {1'b0, hi} + {1'b0, prod[63:0]};
                        if (prod[127:64] != 64'd0 || acc[64])
                            code = tsbc_pkg::ERR_SPAN_OVF;
                        else
                            hi = acc[63:0];
                    end
                end
                if (code == tsbc_pkg::ERR_NONE)
                begin
                    acc = {1'b0, hi} + {1'b0, w};
                    if (acc[64])
                        code = tsbc_pkg::ERR_SPAN_OVF;
                    else
                        hi = acc[63:0];
                end
            end
        end

        if (code == tsbc_pkg::ERR_NONE)
        begin
            floor_b = hi;
            for (int k = 0; k < 4; k++)
                if (str[k] > floor_b)
                    floor_b = str[k];
            if (floor_b[2:0] != 3'd0)
                code = tsbc_pkg::ERR_FLOOR_ALIGN;
        end

        if (code == tsbc_pkg::ERR_NONE)
        begin
            if (d.given_bytes != 64'd0 &&
                (d.given_bytes < floor_b || d.given_bytes[2:0] != 3'd0))
                code = tsbc_pkg::ERR_SUPPLIED;
            else if (d.given_bytes == 64'd0 && !empty)
                code = tsbc_pkg::ERR_NO_BACKING;
        end

        // A rejected descriptor leaves every other field zero
        v.code = code;
        if (code == tsbc_pkg::ERR_NONE)
        begin
            v.ok = 1'b1;
            v.span_low = d.view_offset;
            v.span_high = hi;
            v.is_empty = empty;
            v.backing_size = (d.given_bytes == 64'd0) ? floor_b : d.given_bytes;
        end
        return v;
    endfunction

    // A simple accepted descriptor: 2 x 1 x 1 x 1 of 4-byte elements, 8 bytes
    function automatic tensor_desc_t plain_desc();
        tensor_desc_t d;
        d = '0;
        d.element_type = tsbc_pkg::ELEM_W4_A;
        d.extent_0 = 64'd2;
        d.extent_1 = 64'd1;
        d.extent_2 = 64'd1;
        d.extent_3 = 64'd1;
        d.stride_0 = 64'd4;
        d.stride_1 = 64'd8;
        d.stride_2 = 64'd8;
        d.stride_3 = 64'd8;
        d.given_bytes = 64'd8;
        return d;
    endfunction

    // A value from the corners of the 64-bit range, or a plain random one
    function automatic logic [63:0] corner_value();
        logic [63:0] v;
        int unsigned sh;
        sh = $urandom_range(0, 63);
        case ($urandom_range(0, 6))
            0:       v = 64'd0;
            1:       v = 64'd1;
            2:       v = 64'd1 << sh;
            3:       v = (64'd1 << sh) - 64'd1;
            4:       v = {$urandom, $urandom};
            5:       v = '1;
            default: v = '1 - 64'($urandom_range(0, 15));
        endcase
        return v;
    endfunction

    // A descriptor of small sizes that mostly gets through every check
    function automatic tensor_desc_t wellformed_desc();
        tensor_desc_t d;
        logic [63:0]  w;
        logic [63:0]  hi;
        logic [63:0]  floor_b;
        logic [63:0]  ext [4];
        logic [63:0]  str [4];
        logic [63:0]  fit;
        case ($urandom_range(0, 3))
            0:       d.element_type = tsbc_pkg::ELEM_W4_A;
            1:       d.element_type = tsbc_pkg::ELEM_W4_B;
            2:       d.element_type = tsbc_pkg::ELEM_W2;
            default: d.element_type = tsbc_pkg::ELEM_W8;
        endcase
        w = elem_bytes(d.element_type);
        for (int k = 0; k < 4; k++)
        begin
            ext[k] = 64'($urandom_range(1, 5));
            str[k] = 64'd8 * $urandom_range(0, 64);
        end
        // Keep dimension 0 dense most of the time
        if ($urandom_range(0, 3) != 0)
            str[0] = w;
        if ($urandom_range(0, 99) < 15)
            ext[2'($urandom_range(0, 3))] = 64'd0;
        d.view_flag = ($urandom_range(0, 3) != 0);
        d.view_offset = d.view_flag ? 64'd8 * $urandom_range(0, 512) : 64'd0;

        hi = d.view_offset;
        if (ext[0] != 0 && ext[1] != 0 && ext[2] != 0 && ext[3] != 0)
        begin
            for (int k = 0; k < 4; k++)
                hi = hi + (ext[k] - 64'd1) * str[k];
            hi = hi + w;
        end
        // Pad the offset so that the span end lands on an 8-byte boundary
        if (hi[2:0] != 3'd0 && d.view_flag && $urandom_range(0, 3) != 0)
        begin
            d.view_offset = d.view_offset + (64'd8 - hi[2:0]);
            hi = hi + (64'd8 - hi[2:0]);
        end
        floor_b = hi;
        for (int k = 0; k < 4; k++)
            if (str[k] > floor_b)
                floor_b = str[k];
        fit = (floor_b + 64'd7) & ~64'd7;

        case ($urandom_range(0, 9))
            0, 1, 2: d.given_bytes = 64'd0;
            3, 4:    d.given_bytes = fit;
            5, 6:    d.given_bytes = fit + 64'd8 * $urandom_range(1, 32);
            7:       d.given_bytes = (fit >= 64'd8) ? fit - 64'd8 : 64'd0;
            8:       d.given_bytes = fit + 64'($urandom_range(1, 7));
            default: d.given_bytes = {$urandom, $urandom};
        endcase
        d.extent_0 = ext[0];
        d.extent_1 = ext[1];
        d.extent_2 = ext[2];
        d.extent_3 = ext[3];
        d.stride_0 = str[0];
        d.stride_1 = str[1];
        d.stride_2 = str[2];
        d.stride_3 = str[3];
        return d;
    endfunction

    // Large extents, strides and offsets aimed at the overflow checks
    function automatic tensor_desc_t overflow_desc();
        tensor_desc_t d;
        logic [63:0]  ext [4];
        logic [63:0]  str [4];
        d = wellformed_desc();
        for (int k = 0; k < 4; k++)
        begin
            ext[k] = ($urandom_range(0, 1) == 0) ? 64'd1 : corner_value();
            if ($urandom_range(0, 4) != 0)
                ext[k][63] = 1'b0;
            str[k] = ($urandom_range(0, 2) == 0) ? 64'd8 * $urandom_range(0, 64)
                                                 : corner_value();
        end
        d.extent_0 = ext[0];
        d.extent_1 = ext[1];
        d.extent_2 = ext[2];
        d.extent_3 = ext[3];
        d.stride_0 = str[0];
        d.stride_1 = str[1];
        d.stride_2 = str[2];
        d.stride_3 = str[3];
        if (d.view_flag)
            d.view_offset = corner_value();
        if ($urandom_range(0, 1) == 0)
            d.given_bytes = corner_value() & ~64'd7;
        return d;
    endfunction

    // Every field random over its whole range
    function automatic tensor_desc_t noise_desc();
        tensor_desc_t d;
        d.element_type = 8'($urandom_range(0, 255));
        d.extent_0 = {$urandom, $urandom};
        d.extent_1 = {$urandom, $urandom};
        d.extent_2 = {$urandom, $urandom};
        d.extent_3 = {$urandom, $urandom};
        d.stride_0 = {$urandom, $urandom};
        d.stride_1 = {$urandom, $urandom};
        d.stride_2 = {$urandom, $urandom};
        d.stride_3 = {$urandom, $urandom};
        d.view_flag = 1'($urandom_range(0, 1));
        d.view_offset = {$urandom, $urandom};
        d.given_bytes = {$urandom, $urandom};
        return d;
    endfunction

    // A good descriptor with one thing broken in it
    function automatic tensor_desc_t broken_desc();
        tensor_desc_t d;
        d = wellformed_desc();
        case ($urandom_range(0, 2))
            0:
            begin
                d.view_flag = 1'b0;
                d.view_offset = corner_value() | 64'd8;
            end
            1:
            begin
                do
                    d.element_type = 8'($urandom_range(0, 255));
                while (elem_bytes(d.element_type) != 64'd0);
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       d.extent_0[63] = 1'b1;
                    1:       d.extent_1[63] = 1'b1;
                    2:       d.extent_2[63] = 1'b1;
                    default: d.extent_3[63] = 1'b1;
                endcase
            end
        endcase
        return d;
    endfunction

    // Offer one item, hold it until accepted, then note the verdict owed
    task automatic send_desc(input tensor_desc_t d);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        element_type   <= d.element_type;
        extent_0       <= d.extent_0;
        extent_1       <= d.extent_1;
        extent_2       <= d.extent_2;
        extent_3       <= d.extent_3;
        stride_0       <= d.stride_0;
        stride_1       <= d.stride_1;
        stride_2       <= d.stride_2;
        stride_3       <= d.stride_3;
        view_flag      <= d.view_flag;
        view_offset    <= d.view_offset;
        given_bytes    <= d.given_bytes;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        verdicts_owed.push_back(predict_span(d));
    endtask

    // Hand-picked descriptors: every code, every type and the range corners
    task automatic test_directed();
        tensor_desc_t d;

        // Accepted, and the same without backing
        send_desc(plain_desc());
        d = plain_desc();
        d.given_bytes = 64'd0;
        send_desc(d);

        // Empty tensor with no backing: the floor becomes the backing size
        d = plain_desc();
        d.extent_2 = 64'd0;
        d.given_bytes = 64'd0;
        send_desc(d);

        // Offset given on a tensor that is not a view
        d = plain_desc();
        d.view_offset = 64'd16;
        send_desc(d);

        // Invalid type codes at both ends
        d = plain_desc();
        d.element_type = 8'd2;
        send_desc(d);
        d.element_type = 8'hFF;
        send_desc(d);

        // Remaining type codes; the 8-byte one first leaves the floor misaligned
        d = plain_desc();
        d.element_type = tsbc_pkg::ELEM_W4_B;
        send_desc(d);
        d.element_type = tsbc_pkg::ELEM_W2;
        send_desc(d);
        d.element_type = tsbc_pkg::ELEM_W8;
        send_desc(d);
        d.stride_0 = 64'd8;
        d.given_bytes = 64'd64;
        send_desc(d);

        // Negative extent after the count is already zero, and the most negative
        d = plain_desc();
        d.extent_0 = 64'd0;
        d.extent_3 = '1;
        send_desc(d);
        d = plain_desc();
        d.extent_0 = 64'h8000_0000_0000_0000;
        send_desc(d);

        // Element count overflow
        d = plain_desc();
        d.extent_0 = 64'h1_0000_0000;
        d.extent_1 = 64'h1_0000_0000;
        send_desc(d);

        // Largest extent with a zero stride still fits
        d = plain_desc();
        d.extent_0 = 64'h7FFF_FFFF_FFFF_FFFF;
        d.stride_0 = 64'd0;
        send_desc(d);

        // Span overflow in a term, in the running sum and in the width add
        d = plain_desc();
        d.extent_0 = 64'd3;
        d.stride_0 = 64'h8000_0000_0000_0000;
        send_desc(d);
        d = plain_desc();
        d.view_flag = 1'b1;
        d.view_offset = 64'hFFFF_FFFF_FFFF_FFF0;
        d.stride_0 = 64'd16;
        send_desc(d);
        d = plain_desc();
        d.view_flag = 1'b1;
        d.view_offset = 64'hFFFF_FFFF_FFFF_FFFC;
        d.extent_0 = 64'd1;
        send_desc(d);

        // All-ones stride sets a misaligned floor; an aligned maximum is usable
        d = plain_desc();
        d.stride_3 = '1;
        send_desc(d);
        d.stride_3 = 64'hFFFF_FFFF_FFFF_FFF8;
        d.given_bytes = 64'hFFFF_FFFF_FFFF_FFF8;
        send_desc(d);
        d.given_bytes = '1;
        send_desc(d);

        // Supplied below the floor, and above it but not a multiple of 8
        d = plain_desc();
        d.stride_3 = 64'd64;
        d.given_bytes = 64'd32;
        send_desc(d);
        d.given_bytes = 64'd65;
        send_desc(d);

        // Empty view at the top of the address range
        d = plain_desc();
        d.view_flag = 1'b1;
        d.view_offset = 64'hFFFF_FFFF_FFFF_FFF8;
        d.extent_1 = 64'd0;
        d.given_bytes = 64'd0;
        send_desc(d);
    endtask

    // Mostly well-formed descriptors, with corner values, noise and breakage
    task automatic test_random_mix(input int unsigned n);
        int unsigned r;
        for (int unsigned i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_desc(wellformed_desc());
            else if (r < 75)
                send_desc(overflow_desc());
            else if (r < 88)
                send_desc(noise_desc());
            else
                send_desc(broken_desc());
        end
    endtask

    // Back-to-back traffic with neither side idling
    task automatic test_steady_stream(input int unsigned n);
        in_idle_pct = 0;
        out_idle_pct <= 0;
        test_random_mix(n);
        in_idle_pct = 6;
        out_idle_pct <= 6;
    endtask

    // Hold the receiver off while the sender keeps offering, so the block fills
    task automatic test_backpressure(input int unsigned n);
        in_idle_pct = 0;
        hold_asked = hold_asked + 1;
        test_random_mix(n);
        in_idle_pct = 6;
    endtask

    // Receiver: serve hold-off requests, otherwise stall at random
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_asked != hold_served)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_served <= hold_served + 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < out_idle_pct);
        end
    end

    // Compare each accepted result with the oldest verdict owed
    always @(posedge clk)
    begin
        span_verdict_t exp_v;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdicts_owed.size() == 0)
            begin
                $error("result with no item outstanding");
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                exp_v = verdicts_owed.pop_front();
                if (ok !== exp_v.ok)
                begin
                    $error("ok: expected %0d, actual %0d", exp_v.ok, ok);
                    mismatch_count = mismatch_count + 1;
                end
                if (error_code !== exp_v.code)
                begin
                    $error("error_code: expected %0d, actual %0d", exp_v.code, error_code);
                    mismatch_count = mismatch_count + 1;
                end
                if (span_low !== exp_v.span_low)
                begin
                    $error("span_low: expected %h, actual %h", exp_v.span_low, span_low);
                    mismatch_count = mismatch_count + 1;
                end
                if (span_high !== exp_v.span_high)
                begin
                    $error("span_high: expected %h, actual %h", exp_v.span_high, span_high);
                    mismatch_count = mismatch_count + 1;
                end
                if (is_empty !== exp_v.is_empty)
                begin
                    $error("is_empty: expected %0d, actual %0d", exp_v.is_empty, is_empty);
                    mismatch_count = mismatch_count + 1;
                end
                if (backing_size !== exp_v.backing_size)
                begin
                    $error("backing_size: expected %h, actual %h",
                           exp_v.backing_size, backing_size);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog: end the run if no item moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        // Hold reset, then release it at an edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(1250);
        test_steady_stream(300);
        test_backpressure(120);

        // Drop valid, drain what is owed, then allow for any late extra result
        in_valid <= 1'b0;
        while (verdicts_owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
src/tsbc_pkg.sv
src/tsbc_mul64.sv
src/tensor_span_backing_checker_top.sv
sim/tensor_span_backing_checker_top_tb.sv
